/* rtl/core/cie_pkg.sv */
package cie_pkg;

	// Item kind codes carried on the op field
	typedef enum logic [3:0] {
		OP_SINT   = 4'd0,
		OP_UINT   = 4'd1,
		OP_BSTR   = 4'd2,
		OP_TSTR   = 4'd3,
		OP_ARRAY  = 4'd4,
		OP_MAP    = 4'd5,
		OP_IARRAY = 4'd6,
		OP_IMAP   = 4'd7,
		OP_BREAK  = 4'd8,
		OP_BOOL   = 4'd9,
		OP_TAG    = 4'd10,
		OP_HALF   = 4'd11,
		OP_SINGLE = 4'd12,
		OP_DOUBLE = 4'd13,
		OP_BYTE   = 4'd14,
		OP_CLEAR  = 4'd15
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic clear;
		logic check;
		logic shift;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_op;
		logic last_byte;
	} dp_status_t;

	// Major types, placed in the top three bits of the lead byte by int_head
	localparam logic [2:0] MAJ_UINT  = 3'd0;
	localparam logic [2:0] MAJ_NINT  = 3'd1;
	localparam logic [2:0] MAJ_BSTR  = 3'd2;
	localparam logic [2:0] MAJ_TSTR  = 3'd3;
	localparam logic [2:0] MAJ_ARRAY = 3'd4;
	localparam logic [2:0] MAJ_MAP   = 3'd5;
	localparam logic [2:0] MAJ_TAG   = 3'd6;

	// Additional info for the argument sizes
	localparam logic [4:0] AI_U8  = 5'd24;
	localparam logic [4:0] AI_U16 = 5'd25;
	localparam logic [4:0] AI_U32 = 5'd26;
	localparam logic [4:0] AI_U64 = 5'd27;

	// Single-byte items and float leads
	localparam logic [7:0] LEAD_IARRAY = 8'h9f;
	localparam logic [7:0] LEAD_IMAP   = 8'hbf;
	localparam logic [7:0] LEAD_BREAK  = 8'hff;
	localparam logic [7:0] LEAD_FALSE  = 8'hf4;
	localparam logic [7:0] LEAD_TRUE   = 8'hf5;
	localparam logic [7:0] LEAD_HALF   = 8'hf9;
	localparam logic [7:0] LEAD_SINGLE = 8'hfa;
	localparam logic [7:0] LEAD_DOUBLE = 8'hfb;

	localparam logic [15:0] BUF_SIZE_RESET = 16'hffff;

	// Exponent limits for the single to half conversion
	localparam logic [7:0] EXP_ZERO_LIM = 8'd103;
	localparam logic [7:0] EXP_INF_LIM  = 8'd142;
	localparam logic [7:0] EXP_NORM_LIM = 8'd113;
	localparam logic [7:0] EXP_BIAS_ADJ = 8'd112;
	localparam logic [7:0] EXP_NAN      = 8'hff;

	// Convert float32 bits to half precision, rounding on the first dropped bit
	function automatic logic [15:0] half_from_single(input logic [31:0] f);
		logic        sgn;
		logic [7:0]  e;
		logic [10:0] m;
		logic [11:0] mm;
		logic [3:0]  sh;
		logic [15:0] r;
		logic [4:0]  he;
		sgn = f[31];
		e   = f[30:23];
		m   = f[22:12];
		mm  = {1'b1, m};
		sh  = 4'(8'd114 - e);
		he  = 5'(e - EXP_BIAS_ADJ);
		if (e < EXP_ZERO_LIM) begin
			r = {sgn, 15'd0};
		end else if (e > EXP_INF_LIM) begin
			r = {sgn, 5'h1f, 9'd0, (e == EXP_NAN) && (f[22:0] != 23'd0)};
		end else if (e < EXP_NORM_LIM) begin
			r = {sgn, 15'd0} | {4'd0, (mm >> sh) + {11'd0, mm[sh - 4'd1]}};
		end else begin
			r = {sgn, he, m[10:1]} + {15'd0, m[0]};
		end
		return r;
	endfunction

endpackage

/* rtl/core/cbor_item_encoder.sv */
// Channel | Direction | Handshake             | Word
// input   | in        | in_valid / in_stall   | op, value
// output  | out       | out_valid / out_stall | out_byte, byte_offset, overflow, last
// config  | in        | cfg_valid / cfg_ready | cfg_data (buffer_size)
//
// An item taking n bytes (1 to 9) is taken in, passes the capacity check, then
// leaves one byte per cycle through the output register while the output is not stalled.
// An overflowing item sends one zero byte flagged overflow; a clear-position item only zeroes the write position.
// Reset zeroes the write position and sets the capacity to 65535.
// A stall on the output holds the current byte; no input is taken until the
// final byte of the current item has gone.
module cbor_item_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] byte_offset,
	output logic        overflow,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import cie_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// Capacity writes are always taken
	assign cfg_ready = 1'b1;

	// Sequencer
	cie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Encoder and byte shifter
	cie_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.out_byte    (out_byte),
		.byte_offset (byte_offset),
		.overflow    (overflow),
		.last        (last)
	);

endmodule

/* rtl/core/cie_ctrl.sv */
module cie_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cie_pkg::dp_status_t   st,
	output cie_pkg::dp_cmd_t      cmd
);
	import cie_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (st.clear_op) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.shift = 1'b1;
					if (st.last_byte) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/cie_dp.sv */
module cie_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            op,
	input  logic [63:0]           value,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [15:0]           cfg_data,
	input  cie_pkg::dp_cmd_t      cmd,
	output cie_pkg::dp_status_t   st,
	output logic [7:0]            out_byte,
	output logic [15:0]           byte_offset,
	output logic                  overflow,
	output logic                  last
);
	import cie_pkg::*;

	typedef struct packed {
		logic [71:0] bytes;
		logic [3:0]  cnt;
	} enc_t;

	// Shortest-form head, bytes left aligned with the lead byte on top
	function automatic enc_t int_head(input logic [2:0] major, input logic [63:0] v);
		enc_t r;
		logic [7:0] hi;
		hi = {major, 5'd0};
		if (v < 64'd24) begin
			r.bytes = {hi | {3'd0, v[4:0]}, 64'd0};
			r.cnt   = 4'd1;
		end else if (v <= 64'hff) begin
			r.bytes = {hi | {3'd0, AI_U8}, v[7:0], 56'd0};
			r.cnt   = 4'd2;
		end else if (v <= 64'hffff) begin
			r.bytes = {hi | {3'd0, AI_U16}, v[15:0], 48'd0};
			r.cnt   = 4'd3;
		end else if (v <= 64'hffff_ffff) begin
			r.bytes = {hi | {3'd0, AI_U32}, v[31:0], 32'd0};
			r.cnt   = 4'd5;
		end else begin
			r.bytes = {hi | {3'd0, AI_U64}, v};
			r.cnt   = 4'd9;
		end
		return r;
	endfunction

	logic [71:0] buf_q;
	logic [3:0]  cnt_q;
	logic [15:0] pos_q;
	logic [15:0] bufsize_q;
	logic        ovf_q;
	enc_t        enc;
	logic        no_fit;

	// Encode the incoming word
	always_comb begin
		enc = '0;
		case (op_t'(op))
			OP_SINT: begin
				if (value[63]) begin
					enc = int_head(MAJ_NINT, ~value);
				end else begin
					enc = int_head(MAJ_UINT, value);
				end
			end
			OP_UINT:   enc = int_head(MAJ_UINT, value);
			OP_BSTR:   enc = int_head(MAJ_BSTR, value);
			OP_TSTR:   enc = int_head(MAJ_TSTR, value);
			OP_ARRAY:  enc = int_head(MAJ_ARRAY, value);
			OP_MAP:    enc = int_head(MAJ_MAP, value);
			OP_TAG:    enc = int_head(MAJ_TAG, value);
			OP_IARRAY: enc = '{bytes: {LEAD_IARRAY, 64'd0}, cnt: 4'd1};
			OP_IMAP:   enc = '{bytes: {LEAD_IMAP, 64'd0}, cnt: 4'd1};
			OP_BREAK:  enc = '{bytes: {LEAD_BREAK, 64'd0}, cnt: 4'd1};
			OP_BOOL: begin
				enc = '{bytes: {(value != 64'd0) ? LEAD_TRUE : LEAD_FALSE, 64'd0},
					cnt: 4'd1};
			end
			OP_HALF: begin
				enc = '{bytes: {LEAD_HALF, half_from_single(value[31:0]), 48'd0},
					cnt: 4'd3};
			end
			OP_SINGLE: enc = '{bytes: {LEAD_SINGLE, value[31:0], 32'd0}, cnt: 4'd5};
			OP_DOUBLE: enc = '{bytes: {LEAD_DOUBLE, value}, cnt: 4'd9};
			OP_BYTE:   enc = '{bytes: {value[7:0], 64'd0}, cnt: 4'd1};
			default:   enc = '0;
		endcase
	end

	// Fit check against the buffer capacity
	assign no_fit = ({1'b0, pos_q} + 17'(cnt_q)) >= {1'b0, bufsize_q};

	// Control registers: position, capacity, overflow flag, byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			bufsize_q <= BUF_SIZE_RESET;
			ovf_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bufsize_q <= cfg_data;
			end
			if (cmd.clear) begin
				pos_q <= '0;
			end else if (cmd.shift && !ovf_q) begin
				pos_q <= pos_q + 16'd1;
			end
			if (cmd.load) begin
				cnt_q <= enc.cnt;
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - 4'd1;
			end
			if (cmd.check) begin
				ovf_q <= no_fit;
			end
		end
	end

	// Byte shifter: load the encoding, advance one byte per word taken
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q <= enc.bytes;
		end else if (cmd.shift) begin
			buf_q <= {buf_q[63:0], 8'd0};
		end
	end

	assign st.clear_op  = (op_t'(op) == OP_CLEAR);
	assign st.last_byte = ovf_q || (cnt_q == 4'd1);

	assign out_byte    = ovf_q ? 8'd0 : buf_q[71:64];
	assign byte_offset = pos_q;
	assign overflow    = ovf_q;
	assign last        = st.last_byte;

endmodule
